[hdl/bat_pkg.sv]
// Shared types and constants for the buddy allocator tree.
// Holds node marks, status codes, controller states and the control/status bundles.
// No dependencies.
package bat_pkg;

   // Two-bit mark kept for every tree node.
   typedef logic [1:0] mark_type;
   localparam mark_type MARK_FREE  = 2'd0;
   localparam mark_type MARK_SPLIT = 2'd1;
   localparam mark_type MARK_ALLOC = 2'd2;

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_OVERSIZE  = 2'd1;
   localparam status_type STATUS_NO_BLOCK  = 2'd2;
   localparam status_type STATUS_BAD_OFFS  = 2'd3;

   // Controller states, one-hot.
   typedef enum logic [14:0] {
      ST_CLEAR   = 15'b000000000000001,
      ST_IDLE    = 15'b000000000000010,
      ST_CHECK   = 15'b000000000000100,
      ST_LEVEL   = 15'b000000000001000,
      ST_A_RD    = 15'b000000000010000,
      ST_A_CHK   = 15'b000000000100000,
      ST_A_ADV   = 15'b000000001000000,
      ST_A_MARK  = 15'b000000010000000,
      ST_A_SPLIT = 15'b000000100000000,
      ST_F_LOC   = 15'b000001000000000,
      ST_F_RD    = 15'b000010000000000,
      ST_F_CHK   = 15'b000100000000000,
      ST_M_RD    = 15'b001000000000000,
      ST_M_CHK   = 15'b010000000000000,
      ST_DONE    = 15'b100000000000000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       clear_step;
      logic       load;
      logic       level_step;
      logic       locate;
      logic       read_buddy;
      logic       descend;
      logic       ascend;
      logic       sibling;
      logic       wr_en;
      logic       wr_parent;
      mark_type   wr_mark;
      logic       set_result;
      status_type result_status;
      logic       grant_en;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic     clear_done;
      logic     can_halve;
      logic     at_root;
      logic     node_even;
      logic     at_target;
      mark_type mark;
      logic     oversize;
      logic     offset_bad;
      logic     is_free;
   } dp_stat_type;

endpackage

[hdl/bat_datapath.sv]
// Datapath of the buddy allocator: node mark memory, request registers, tree walk
// index and result registers. Uses bat_pkg; driven by bat_ctrl commands.
module bat_datapath #(
   parameter int POOL_BYTES      = 4096,
   parameter int MIN_BLOCK_BYTES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  bat_pkg::dp_cmd_type cmd,
   output bat_pkg::dp_stat_type stat,
   input  logic                req_operation,
   input  logic [12:0]         req_request_size,
   input  logic [11:0]         req_block_offset,
   output logic [1:0]          rsp_status,
   output logic [11:0]         rsp_granted_offset
);

   localparam int POOL_LOG   = $clog2(POOL_BYTES);
   localparam int MIN_LOG    = $clog2(MIN_BLOCK_BYTES);
   localparam int TREE_DEPTH = POOL_LOG - MIN_LOG;
   localparam int IDX_W      = TREE_DEPTH + 1;
   localparam int NODE_SLOTS = 1 << IDX_W;
   localparam int SH_W       = $clog2(POOL_LOG + 1);
   localparam int LV_W       = (TREE_DEPTH < 1) ? 1 : $clog2(TREE_DEPTH + 1);
   localparam int SZ_W       = (POOL_LOG + 1 > 13) ? POOL_LOG + 1 : 13;
   localparam int GW         = POOL_LOG + 12;

   bat_pkg::mark_type    mem [NODE_SLOTS];
   bat_pkg::mark_type    rd_data_ff;
   logic [IDX_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                 op_ff;
   logic [SZ_W-1:0]      size_ff;
   logic [11:0]          offs_ff;
   logic [SH_W-1:0]      blk_shift_ff, blk_shift_in;
   logic [LV_W-1:0]      tgt_level_ff, tgt_level_in;
   logic [LV_W-1:0]      cur_level_ff, cur_level_in;
   logic [IDX_W-1:0]     node_ff, node_in;
   bat_pkg::status_type  status_ff;
   logic [11:0]          grant_ff;

   logic [SZ_W-1:0]      size_clamped;
   logic [SZ_W-1:0]      half;
   logic                 can_halve;
   logic [IDX_W-1:0]     first;
   logic [IDX_W-1:0]     parent;
   logic [IDX_W-1:0]     buddy;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;
   bat_pkg::mark_type    wr_data;
   logic                 wr_en;
   logic [GW-1:0]        grant_wide;

   // Size below the minimum block counts as one minimum block.
   assign size_clamped = (SZ_W'(req_request_size) < SZ_W'(MIN_BLOCK_BYTES))
                         ? SZ_W'(MIN_BLOCK_BYTES) : SZ_W'(req_request_size);

   // Level search: halve the block while the half still holds the request.
   assign half      = SZ_W'(1) << (blk_shift_ff - SH_W'(1));
   assign can_halve = (blk_shift_ff > SH_W'(MIN_LOG)) && (half >= size_ff);

   // Tree index arithmetic.
   assign first      = (IDX_W'(1) << tgt_level_ff) - IDX_W'(1);
   assign parent     = (node_ff - IDX_W'(1)) >> 1;
   assign buddy      = node_ff[0] ? node_ff + IDX_W'(1) : node_ff - IDX_W'(1);
   assign grant_wide = GW'(node_ff - first) << blk_shift_ff;

   // Memory port selection.
   assign rd_addr = cmd.read_buddy ? buddy : node_ff;
   assign wr_en   = cmd.clear_step | cmd.wr_en;
   assign wr_addr = cmd.clear_step ? clr_cnt_ff : (cmd.wr_parent ? parent : node_ff);
   assign wr_data = cmd.clear_step ? bat_pkg::MARK_FREE : cmd.wr_mark;

   // Node mark memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Clearing pass counter.
   assign clr_cnt_in = cmd.clear_step ? clr_cnt_ff + IDX_W'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Walk position and level bookkeeping.
   always_comb begin
      blk_shift_in = blk_shift_ff;
      tgt_level_in = tgt_level_ff;
      cur_level_in = cur_level_ff;
      node_in      = node_ff;
      if (cmd.load) begin
         blk_shift_in = SH_W'(POOL_LOG);
         tgt_level_in = '0;
         cur_level_in = '0;
         node_in      = '0;
      end else if (cmd.level_step) begin
         blk_shift_in = blk_shift_ff - SH_W'(1);
         tgt_level_in = tgt_level_ff + LV_W'(1);
      end else if (cmd.locate) begin
         node_in = first + IDX_W'(offs_ff >> blk_shift_ff);
      end else if (cmd.descend) begin
         node_in      = (node_ff << 1) | IDX_W'(1);
         cur_level_in = cur_level_ff + LV_W'(1);
      end else if (cmd.ascend) begin
         node_in      = parent;
         cur_level_in = cur_level_ff - LV_W'(1);
      end else if (cmd.sibling) begin
         node_in = node_ff + IDX_W'(1);
      end
   end

   // Request and result registers.
   always_ff @(posedge clock) begin
      blk_shift_ff <= blk_shift_in;
      tgt_level_ff <= tgt_level_in;
      cur_level_ff <= cur_level_in;
      node_ff      <= node_in;
      if (cmd.load) begin
         op_ff     <= req_operation;
         size_ff   <= size_clamped;
         offs_ff   <= req_block_offset;
         status_ff <= bat_pkg::STATUS_OK;
         grant_ff  <= '0;
      end else if (cmd.set_result) begin
         status_ff <= cmd.result_status;
         if (cmd.grant_en) begin
            grant_ff <= grant_wide[11:0];
         end
      end
   end

   // Status back to the controller.
   always_comb begin
      stat.clear_done = &clr_cnt_ff;
      stat.can_halve  = can_halve;
      stat.at_root    = (node_ff == '0);
      stat.node_even  = ~node_ff[0];
      stat.at_target  = (cur_level_ff == tgt_level_ff);
      stat.mark       = rd_data_ff;
      stat.oversize   = size_ff > SZ_W'(POOL_BYTES);
      stat.offset_bad = SZ_W'(offs_ff) >= SZ_W'(POOL_BYTES);
      stat.is_free    = op_ff;
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_offset = grant_ff;

endmodule

[hdl/bat_ctrl.sv]
// Controller of the buddy allocator: sequences clearing, level search, the
// allocation tree walk and the free/merge walk. Uses bat_pkg; drives bat_datapath.
module bat_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output bat_pkg::dp_cmd_type  cmd,
   input  bat_pkg::dp_stat_type stat
);

   bat_pkg::state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         bat_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = bat_pkg::ST_IDLE;
            end
         end
         bat_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = bat_pkg::ST_CHECK;
            end
         end
         bat_pkg::ST_CHECK: begin
            if (stat.oversize) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = bat_pkg::STATUS_OVERSIZE;
               state_in          = bat_pkg::ST_DONE;
            end else if (stat.is_free && stat.offset_bad) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = bat_pkg::STATUS_BAD_OFFS;
               state_in          = bat_pkg::ST_DONE;
            end else begin
               state_in = bat_pkg::ST_LEVEL;
            end
         end
         bat_pkg::ST_LEVEL: begin
            if (stat.can_halve) begin
               cmd.level_step = 1'b1;
            end else if (stat.is_free) begin
               state_in = bat_pkg::ST_F_LOC;
            end else begin
               state_in = bat_pkg::ST_A_RD;
            end
         end
         bat_pkg::ST_A_RD: begin
            state_in = bat_pkg::ST_A_CHK;
         end
         bat_pkg::ST_A_CHK: begin
            if (stat.at_target) begin
               state_in = (stat.mark == bat_pkg::MARK_FREE) ? bat_pkg::ST_A_MARK
                                                           : bat_pkg::ST_A_ADV;
            end else if (stat.mark == bat_pkg::MARK_ALLOC) begin
               state_in = bat_pkg::ST_A_ADV;
            end else begin
               cmd.descend = 1'b1;
               state_in    = bat_pkg::ST_A_RD;
            end
         end
         bat_pkg::ST_A_ADV: begin
            // Move to the next subtree to the right, climbing past right children.
            if (stat.at_root) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = bat_pkg::STATUS_NO_BLOCK;
               state_in          = bat_pkg::ST_DONE;
            end else if (stat.node_even) begin
               cmd.ascend = 1'b1;
            end else begin
               cmd.sibling = 1'b1;
               state_in    = bat_pkg::ST_A_RD;
            end
         end
         bat_pkg::ST_A_MARK: begin
            cmd.wr_en         = 1'b1;
            cmd.wr_mark       = bat_pkg::MARK_ALLOC;
            cmd.set_result    = 1'b1;
            cmd.result_status = bat_pkg::STATUS_OK;
            cmd.grant_en      = 1'b1;
            state_in          = bat_pkg::ST_A_SPLIT;
         end
         bat_pkg::ST_A_SPLIT: begin
            if (stat.at_root) begin
               state_in = bat_pkg::ST_DONE;
            end else begin
               cmd.ascend    = 1'b1;
               cmd.wr_en     = 1'b1;
               cmd.wr_parent = 1'b1;
               cmd.wr_mark   = bat_pkg::MARK_SPLIT;
            end
         end
         bat_pkg::ST_F_LOC: begin
            cmd.locate = 1'b1;
            state_in   = bat_pkg::ST_F_RD;
         end
         bat_pkg::ST_F_RD: begin
            state_in = bat_pkg::ST_F_CHK;
         end
         bat_pkg::ST_F_CHK: begin
            if (stat.mark == bat_pkg::MARK_ALLOC) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_mark = bat_pkg::MARK_FREE;
               state_in    = bat_pkg::ST_M_RD;
            end else begin
               state_in = bat_pkg::ST_DONE;
            end
         end
         bat_pkg::ST_M_RD: begin
            cmd.read_buddy = 1'b1;
            state_in       = stat.at_root ? bat_pkg::ST_DONE : bat_pkg::ST_M_CHK;
         end
         bat_pkg::ST_M_CHK: begin
            // The node itself is known free here; merge when its buddy is too.
            if (stat.mark == bat_pkg::MARK_FREE) begin
               cmd.ascend    = 1'b1;
               cmd.wr_en     = 1'b1;
               cmd.wr_parent = 1'b1;
               cmd.wr_mark   = bat_pkg::MARK_FREE;
               state_in      = bat_pkg::ST_M_RD;
            end else begin
               state_in = bat_pkg::ST_DONE;
            end
         end
         bat_pkg::ST_DONE: begin
            state_in = bat_pkg::ST_IDLE;
         end
         default: begin
            state_in = bat_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bat_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != bat_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == bat_pkg::ST_DONE);

endmodule

[hdl/buddy_allocator_tree.sv]
// Top level of the binary buddy allocator: joins the controller and the datapath.
// Depends on bat_pkg, bat_ctrl and bat_datapath.
//
// After reset the block sweeps its node mark memory, one node per cycle, through
// every node and holds busy high meanwhile. An item is taken when start is high and
// busy is low; exactly one result follows, shown for one cycle with rsp_valid, and
// the receiver cannot stall it. An oversize request or a free with an offset outside
// the pool ends right after the check. Any other request first halves the block
// level by level; then an allocate reads nodes in a left-to-right tree walk, with
// steps to the right and climbs past right children, a granted allocate marks each
// ancestor split, and a full level reports no block. A free locates and reads its
// node; when the node was allocated it frees it and merges buddy pairs upward until
// merging reaches the root or a buddy is not free. Every node read takes a read
// state and a check state because the memory returns its read data registered. Busy
// stays high through the result cycle, so the next item is taken in the cycle after
// the result at the earliest.
module buddy_allocator_tree #(
   parameter int POOL_BYTES      = 4096,
   parameter int MIN_BLOCK_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [12:0] req_request_size,
   input  logic [11:0] req_block_offset,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_granted_offset
);

   bat_pkg::dp_cmd_type  cmd;
   bat_pkg::dp_stat_type stat;

   bat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   bat_datapath #(
      .POOL_BYTES      (POOL_BYTES),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_request_size   (req_request_size),
      .req_block_offset   (req_block_offset),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset)
   );

   // A result only appears while an item is in flight.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while idle");

   // An accepted item makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Each result strobe lasts a single cycle and is followed by idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("result strobe not followed by idle");

   // A failed request never reports a granted offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bat_pkg::STATUS_OK) |-> (rsp_granted_offset == '0))
      else $error("granted offset on a failed request");

endmodule

[dv/bat_checker.sv]
// Result checker for the buddy allocator tree: keeps its own node mark tree,
// predicts the status and offset of every accepted item and compares them.
// Depends on bat_pkg.
module bat_checker #(
   parameter int POOL_BYTES      = 4096,
   parameter int MIN_BLOCK_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_operation,
   input  logic [12:0] req_request_size,
   input  logic [11:0] req_block_offset,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [11:0] rsp_granted_offset,
   output int          fail_count,
   output int          pending_count
);

   localparam int NODES = 2 * POOL_BYTES / MIN_BLOCK_BYTES;

   typedef struct packed {
      bat_pkg::status_type status;
      logic [11:0]         granted;
   } grant_type;

   bat_pkg::mark_type tree_marks [NODES];
   grant_type         grants_due [$];

   function automatic bat_pkg::mark_type mark_of(int n);
      return (n < NODES) ? tree_marks[n] : bat_pkg::MARK_ALLOC;
   endfunction

   // Level and block size for a size already clamped to the pool.
   function automatic int level_of(int size, output int blk);
      int b;
      int lvl;
      b = POOL_BYTES;
      lvl = 0;
      while (b > MIN_BLOCK_BYTES && b / 2 >= size) begin
         b = b / 2;
         lvl++;
      end
      blk = b;
      return lvl;
   endfunction

   // Applies one item to the tree and returns the expected result.
   function automatic grant_type allocate_or_free(logic op, int size, int offs);
      grant_type g;
      int blk;
      int lvl;
      int n;
      int a;
      int buddy;
      bit clear;
      g.status = bat_pkg::STATUS_OK;
      g.granted = '0;
      if (size < MIN_BLOCK_BYTES) size = MIN_BLOCK_BYTES;
      if (size > POOL_BYTES) begin
         g.status = bat_pkg::STATUS_OVERSIZE;
      end else if (op == 1'b0) begin
         lvl = level_of(size, blk);
         g.status = bat_pkg::STATUS_NO_BLOCK;
         for (int i = 0; i < (1 << lvl); i++) begin
            n = (1 << lvl) - 1 + i;
            if (n >= NODES) break;
            if (mark_of(n) == bat_pkg::MARK_FREE) begin
               clear = 1;
               a = n;
               while (a != 0) begin
                  a = (a - 1) / 2;
                  if (mark_of(a) == bat_pkg::MARK_ALLOC) clear = 0;
               end
               if (clear) begin
                  tree_marks[n] = bat_pkg::MARK_ALLOC;
                  a = n;
                  while (a != 0) begin
                     a = (a - 1) / 2;
                     tree_marks[a] = bat_pkg::MARK_SPLIT;
                  end
                  g.granted = 12'(i * blk);
                  g.status = bat_pkg::STATUS_OK;
                  break;
               end
            end
         end
      end else if (offs >= POOL_BYTES) begin
         g.status = bat_pkg::STATUS_BAD_OFFS;
      end else begin
         lvl = level_of(size, blk);
         n = (1 << lvl) - 1 + offs / blk;
         if (n < NODES && mark_of(n) == bat_pkg::MARK_ALLOC) begin
            tree_marks[n] = bat_pkg::MARK_FREE;
            // Merge free buddy pairs upward.
            while (n != 0) begin
               buddy = (n & 1) ? n + 1 : n - 1;
               if (mark_of(n) != bat_pkg::MARK_FREE || mark_of(buddy) != bat_pkg::MARK_FREE)
                  break;
               n = (n - 1) / 2;
               tree_marks[n] = bat_pkg::MARK_FREE;
            end
         end
      end
      return g;
   endfunction

   assign pending_count = grants_due.size();

   // Predict on every accepted item, compare every strobed result.
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         for (int i = 0; i < NODES; i++) tree_marks[i] = bat_pkg::MARK_FREE;
         grants_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected result: status %0d offset %0d",
                           rsp_status, rsp_granted_offset);
            end else begin
               want = grants_due.pop_front();
               if (want.status !== rsp_status || want.granted !== rsp_granted_offset) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected status %0d offset %0d, got %0d %0d",
                              want.status, want.granted, rsp_status, rsp_granted_offset);
               end
            end
         end
         if (start && !busy)
            grants_due.push_back(allocate_or_free(req_operation,
                                 int'(req_request_size), int'(req_block_offset)));
      end
   end
endmodule

[dv/tb_top.sv]
// Stimulus and verdict for the buddy allocator tree; results are checked by
// bat_checker. Depends on bat_checker and buddy_allocator_tree.
module tb_top;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_operation = 0;
   logic [12:0] req_request_size = '0;
   logic [11:0] req_block_offset = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_granted_offset;
   int          fail_count;
   int          pending_count;

   // Offsets handed out so far, with their sizes, for well-formed frees.
   int live_offs [$];
   int live_size [$];

   always #5 clock = ~clock;

   buddy_allocator_tree u_top (.*);
   bat_checker u_chk (.*);

   // Drives one item and waits until it is taken. The block stays busy through its
   // check and result states after taking an item, so the opening edge costs no rate.
   task automatic send_item(logic op, int size, int offs, bit quiet);
      @(posedge clock);
      if (!quiet && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 15)) @(posedge clock);
      start <= 1;
      req_operation <= op;
      req_request_size <= 13'(size);
      req_block_offset <= 12'(offs);
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 0;
   endtask

   // Waits for the edge that ends the result cycle of the item just taken.
   task automatic wait_result();
      do @(posedge clock); while (!rsp_valid);
   endtask

   // Waits until the block is idle and all expected results have come.
   task automatic drain();
      @(posedge clock);
      while (busy || pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // A random size, mostly small powers of two, sometimes odd or oversize.
   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 8 << $urandom_range(0, 4);
      if (r < 8) return $urandom_range(0, 300);
      if (r < 9) return 1 << $urandom_range(0, 12);
      return $urandom_range(0, 8191);
   endfunction

   initial begin
      int sz;
      int k;
      int idx;
      int got;
      bit quiet;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: extremes, small and oversize sizes, offsets at the top of the pool, full level.
      send_item(0, 0, 0, 1);
      send_item(0, 4096, 0, 1);
      send_item(1, 8, 0, 1);
      send_item(0, 4096, 0, 1);
      send_item(0, 8, 0, 1);
      send_item(1, 4096, 0, 1);
      send_item(1, 4096, 4095, 1);
      send_item(0, 4097, 0, 1);
      send_item(0, 8191, 0, 1);
      send_item(1, 8191, 4095, 1);
      send_item(1, 8, 4095, 1);
      send_item(1, 8, 4096 - 1, 1);
      send_item(0, 2048, 0, 1);
      send_item(0, 2047, 0, 1);
      send_item(0, 1, 0, 1);
      send_item(1, 2048, 2049, 1);
      send_item(1, 2048, 5, 1);
      send_item(1, 16, 2048, 1);
      send_item(1, 2048, 2048, 1);
      send_item(0, 7, 0, 1);
      send_item(1, 0, 8, 1);
      send_item(1, 3000, 100, 1);
      drain();
      // Random: allocs with matching frees, plus noise.
      for (int i = 0; i < 1900; i++) begin
         quiet = (i > 1700);
         if (i == 900) drain();
         k = $urandom_range(0, 9);
         if (k < 5 || live_offs.size() == 0) begin
            k = 0;
            sz = pick_size();
            send_item(0, sz, $urandom_range(0, 4095), quiet);
            // Track the grant from the result port once it is strobed.
            wait_result();
            got = rsp_granted_offset;
         end else if (k < 9) begin
            idx = $urandom_range(0, live_offs.size() - 1);
            send_item(1, live_size[idx], live_offs[idx] + $urandom_range(0, 1),
                      quiet);
            live_offs.delete(idx);
            live_size.delete(idx);
         end else begin
            send_item(1, pick_size(), $urandom_range(0, 4095), quiet);
         end
         if (live_offs.size() > 60) begin
            live_offs.delete(0);
            live_size.delete(0);
         end
         if (k < 5) begin
            live_offs.push_back(got);
            live_size.push_back(sz);
         end
      end
      drain();
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #400000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
